// File: rtl/core/bmpfb_pkg.sv
// Shared types and constants for the BMP pixel stream to framebuffer block.
package bmpfb_pkg;

	// Fixed field widths of the ports
	localparam int IMG_DIM_W  = 11;
	localparam int ORIGIN_W   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FB_INDEX_W = 19;
	localparam int COLOR_W    = 32;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_MIRROR_COLS  = 3'd2,
		REG_ROWS_TOPDOWN = 3'd3,
		REG_FOUR_BYTE    = 3'd4,
		REG_ORIGIN_X     = 3'd5,
		REG_ORIGIN_Y     = 3'd6
	} cfg_reg_t;

	// Position of the next byte within a pixel
	typedef enum logic [1:0] {
		PH_BLUE  = 2'd0,
		PH_GREEN = 2'd1,
		PH_RED   = 2'd2,
		PH_ALPHA = 2'd3
	} byte_phase_t;

endpackage

// File: rtl/core/bmp_pixel_stream_to_framebuffer.sv
// Top level: unpacks BMP pixel-array bytes into framebuffer index and ARGB color items.
// Throughput: one byte item per cycle while the output is not stalled, with no bubbles between images.
// The result for a pixel is registered in the unpack and placement stage, then in the index
//   stage with the row multiplier, before it is valid at the output.
// Reset: all counters clear, the block idles until a byte flagged as image start;
//   image width and height reset to 1, the other registers to 0.
module bmp_pixel_stream_to_framebuffer
	import bmpfb_pkg::*;
#(
	parameter int FB_WIDTH  = 800,
	parameter int FB_HEIGHT = 480,
	parameter int DIM_BITS  = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  image_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  write_enable,
	output logic [FB_INDEX_W-1:0] fb_index,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  image_done,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Widths of the size arithmetic and of the signed destination coordinates
	localparam int EW   = (DIM_BITS > IMG_DIM_W ? DIM_BITS : IMG_DIM_W) + 1;
	localparam int CW   = EW + 2;
	localparam logic [EW-1:0] DIM_MAX = EW'((1 << DIM_BITS) - 1);
	localparam int XB   = (FB_WIDTH > 1) ? $clog2(FB_WIDTH) : 1;
	localparam int YB   = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;
	localparam int LINW = (XB + YB + 2 > FB_INDEX_W) ? XB + YB + 2 : FB_INDEX_W;

	// Configuration registers
	logic [IMG_DIM_W-1:0]       cfg_width_q, cfg_height_q;
	logic                       cfg_mirror_q, cfg_topdown_q, cfg_four_q;
	logic signed [ORIGIN_W-1:0] cfg_origin_x_q, cfg_origin_y_q;

	// Unpacker state
	byte_phase_t         phase_q;
	logic [1:0]          pad_q;
	logic [DIM_BITS-1:0] col_q, row_q;
	logic                fin_q;
	logic [23:0]         held_q;

	// Stage 1: unpacked pixel with destination coordinates
	logic                s1_valid;
	logic signed [CW-1:0] dx_s1, dy_s1;
	logic [COLOR_W-1:0]  color_s1;
	logic                done_s1;

	// Stage 2: result register
	logic                  valid_s2;
	logic                  we_s2;
	logic [FB_INDEX_W-1:0] index_s2;
	logic [COLOR_W-1:0]    color_s2;
	logic                  done_s2;

	logic in_fire, ready1, ready2;

	// Handshake: each stage takes a new item when it is empty or drains this cycle
	assign ready2    = !valid_s2 || out_ready;
	assign ready1    = !s1_valid || ready2;
	assign in_ready  = ready1;
	assign in_fire   = in_valid && ready1;
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q    <= IMG_DIM_W'(1);
			cfg_height_q   <= IMG_DIM_W'(1);
			cfg_mirror_q   <= 1'b0;
			cfg_topdown_q  <= 1'b0;
			cfg_four_q     <= 1'b0;
			cfg_origin_x_q <= '0;
			cfg_origin_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  cfg_width_q    <= cfg_data[IMG_DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_height_q   <= cfg_data[IMG_DIM_W-1:0];
				REG_MIRROR_COLS:  cfg_mirror_q   <= cfg_data[0];
				REG_ROWS_TOPDOWN: cfg_topdown_q  <= cfg_data[0];
				REG_FOUR_BYTE:    cfg_four_q     <= cfg_data[0];
				REG_ORIGIN_X:     cfg_origin_x_q <= cfg_data[ORIGIN_W-1:0];
				REG_ORIGIN_Y:     cfg_origin_y_q <= cfg_data[ORIGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective sizes: zero counts as one, saturate to the counter range
	logic [EW-1:0] w_raw, h_raw, w_eff, h_eff;
	always_comb begin
		w_raw = EW'(cfg_width_q);
		h_raw = EW'(cfg_height_q);
		w_eff = (w_raw == '0) ? EW'(1) : ((w_raw > DIM_MAX) ? DIM_MAX : w_raw);
		h_eff = (h_raw == '0) ? EW'(1) : ((h_raw > DIM_MAX) ? DIM_MAX : h_raw);
	end

	// Byte unpacking, padding skip and column/row tracking
	byte_phase_t         ph, ph_n;
	logic [1:0]          pad, pad_n;
	logic [DIM_BITS-1:0] col, row, col_n, row_n;
	logic                fin, fin_n;
	logic [23:0]         held_n;
	logic [7:0]          alpha;
	logic                res_valid, res_done;
	logic [EW-1:0]       col_inc, row_inc;

	always_comb begin
		ph        = image_start ? PH_BLUE : phase_q;
		pad       = image_start ? 2'd0 : pad_q;
		col       = image_start ? '0 : col_q;
		row       = image_start ? '0 : row_q;
		fin       = image_start ? 1'b0 : fin_q;
		ph_n      = ph;
		pad_n     = pad;
		col_n     = col;
		row_n     = row;
		fin_n     = fin;
		held_n    = held_q;
		alpha     = 8'd0;
		res_valid = 1'b0;
		res_done  = 1'b0;
		col_inc   = EW'(col) + EW'(1);
		row_inc   = EW'(row) + EW'(1);
		if (!fin) begin
			if (pad != 2'd0) begin
				// drop one padding byte
				pad_n = pad - 2'd1;
			end else begin
				unique case (ph)
					PH_BLUE: begin
						held_n[7:0] = data_byte;
						ph_n        = PH_GREEN;
					end
					PH_GREEN: begin
						held_n[15:8] = data_byte;
						ph_n         = PH_RED;
					end
					PH_RED: begin
						held_n[23:16] = data_byte;
						if (cfg_four_q) begin
							ph_n = PH_ALPHA;
						end else begin
							ph_n      = PH_BLUE;
							res_valid = 1'b1;
						end
					end
					PH_ALPHA: begin
						alpha     = data_byte;
						ph_n      = PH_BLUE;
						res_valid = 1'b1;
					end
				endcase
				// advance column, then row at the end of a row
				if (res_valid) begin
					if (col_inc >= w_eff) begin
						col_n = '0;
						pad_n = cfg_four_q ? 2'd0 : w_eff[1:0];
						if (row_inc >= h_eff) begin
							row_n    = '0;
							res_done = 1'b1;
							fin_n    = 1'b1;
							pad_n    = 2'd0;
						end else begin
							row_n = row_inc[DIM_BITS-1:0];
						end
					end else begin
						col_n = col_inc[DIM_BITS-1:0];
					end
				end
			end
		end
	end

	// Destination coordinates of the finished pixel
	logic signed [CW-1:0] dx, dy, col_s, row_s, w_s, h_s;
	always_comb begin
		col_s = CW'(col);
		row_s = CW'(row);
		w_s   = CW'(w_eff);
		h_s   = CW'(h_eff);
		dx    = (cfg_mirror_q ? (w_s - CW'(1) - col_s) : col_s) + CW'(cfg_origin_x_q);
		dy    = (cfg_topdown_q ? row_s : (h_s - CW'(1) - row_s)) + CW'(cfg_origin_y_q);
	end

	// Unpacker state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLUE;
			pad_q   <= 2'd0;
			col_q   <= '0;
			row_q   <= '0;
			fin_q   <= 1'b1;
		end else if (in_fire) begin
			phase_q <= ph_n;
			pad_q   <= pad_n;
			col_q   <= col_n;
			row_q   <= row_n;
			fin_q   <= fin_n;
		end
	end

	// Hold the color bytes of the pixel in progress
	always_ff @(posedge clk) begin
		if (in_fire) begin
			held_q <= held_n;
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (ready1) begin
			s1_valid <= in_fire && res_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			dx_s1    <= dx;
			dy_s1    <= dy;
			color_s1 <= {alpha, held_n};
			done_s1  <= res_done;
		end
	end

	// Clip against the framebuffer and form the linear index
	logic            on_fb;
	logic [XB-1:0]   dx_lo;
	logic [YB-1:0]   dy_lo;
	logic [LINW-1:0] lin;
	always_comb begin
		on_fb = !dx_s1[CW-1] && (dx_s1 < CW'(FB_WIDTH))
			&& !dy_s1[CW-1] && (dy_s1 < CW'(FB_HEIGHT));
		dx_lo = dx_s1[XB-1:0];
		dy_lo = dy_s1[YB-1:0];
		lin   = LINW'(dy_lo) * LINW'(FB_WIDTH) + LINW'(dx_lo);
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready2) begin
			valid_s2 <= s1_valid;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (ready2 && s1_valid) begin
			we_s2    <= on_fb;
			index_s2 <= on_fb ? lin[FB_INDEX_W-1:0] : '0;
			color_s2 <= color_s1;
			done_s2  <= done_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = we_s2;
	assign fb_index     = index_s2;
	assign pixel_color  = color_s2;
	assign image_done   = done_s2;

	// Finishing an image leaves the block idle until the next start byte
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res_done |=> fin_q)
		else $error("image end did not set the finished flag");

	// Padding is only skipped between pixels
	a_pad_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q != 2'd0 |-> phase_q == PH_BLUE && !cfg_four_q || pad_q == 2'd0 || cfg_four_q)
		else $error("padding pending in the middle of a pixel");

	// An off-screen pixel carries index zero
	a_off_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> fb_index == '0)
		else $error("off-screen pixel with nonzero index");

	// Stage 1 is never lost while the output is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !ready2 |=> s1_valid && $stable(color_s1))
		else $error("stage 1 item dropped under stall");

endmodule

// File: verif/tb_bmp_pixel_stream_to_framebuffer.sv
// Testbench for bmp_pixel_stream_to_framebuffer: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb_bmp_pixel_stream_to_framebuffer;
	import bmpfb_pkg::*;

	localparam int FB_W         = 800;
	localparam int FB_H         = 480;
	localparam int DIM_B        = 11;
	localparam int RANDOM_BYTES = 750;
	localparam int SETTLE       = 8;
	localparam int MAX_REPORTS  = 10;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		logic                  we;
		logic [FB_INDEX_W-1:0] fb_idx;
		logic [COLOR_W-1:0]    color;
		logic                  done;
	} fb_write_t;

	// Tracks the unpacker state and holds the framebuffer writes still due
	class pixel_scoreboard;
		fb_write_t          expected_writes[$];
		int                 errors;
		logic [DIM_B-1:0]   width_r, height_r;
		logic               mirror_r, topdown_r, four_r;
		logic signed [11:0] ox_r, oy_r;
		byte_phase_t        phase;
		logic [1:0]         pad_left;
		logic [DIM_B-1:0]   col, row;
		logic [23:0]        bgr;
		logic               finished;

		function void reset_all();
			errors    = 0;
			width_r   = 1;
			height_r  = 1;
			mirror_r  = 0;
			topdown_r = 0;
			four_r    = 0;
			ox_r      = 0;
			oy_r      = 0;
			phase     = PH_BLUE;
			pad_left  = 0;
			col       = 0;
			row       = 0;
			bgr       = 0;
			finished  = 1;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH:  width_r   = value[DIM_B-1:0];
				REG_IMAGE_HEIGHT: height_r  = value[DIM_B-1:0];
				REG_MIRROR_COLS:  mirror_r  = value[0];
				REG_ROWS_TOPDOWN: topdown_r = value[0];
				REG_FOUR_BYTE:    four_r    = value[0];
				REG_ORIGIN_X:     ox_r      = value[11:0];
				REG_ORIGIN_Y:     oy_r      = value[11:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_writes.size();
		endfunction

		// Advance the unpacker by one byte; return 1 unless the byte is ignored
		function bit accept_byte(logic [7:0] value, logic first);
			int        w, h, dx, dy;
			logic [7:0] alpha;
			fb_write_t px;
			w = (width_r == 0) ? 1 : int'(width_r);
			h = (height_r == 0) ? 1 : int'(height_r);
			alpha = 8'd0;
			if (first) begin
				phase    = PH_BLUE;
				pad_left = 0;
				col      = 0;
				row      = 0;
				finished = 0;
			end
			if (finished)
				return 0;
			// drop row padding
			if (pad_left != 0) begin
				pad_left = pad_left - 2'd1;
				return 1;
			end
			case (phase)
				PH_BLUE: begin
					bgr[7:0] = value;
					phase = PH_GREEN;
					return 1;
				end
				PH_GREEN: begin
					bgr[15:8] = value;
					phase = PH_RED;
					return 1;
				end
				PH_RED: begin
					bgr[23:16] = value;
					if (four_r) begin
						phase = PH_ALPHA;
						return 1;
					end
				end
				default: alpha = value;
			endcase
			phase = PH_BLUE;

			// place the finished pixel
			dx = mirror_r ? w - 1 - int'(col) : int'(col);
			dy = topdown_r ? int'(row) : h - 1 - int'(row);
			dx += ox_r;
			dy += oy_r;
			px.we    = (dx >= 0 && dx < FB_W && dy >= 0 && dy < FB_H);
			px.fb_idx = px.we ? FB_INDEX_W'(dy * FB_W + dx) : '0;
			px.color = {alpha, bgr};
			px.done  = 0;

			// advance column, row and image
			if (int'(col) + 1 >= w) begin
				col = 0;
				pad_left = four_r ? 2'd0 : 2'(w);
				if (int'(row) + 1 >= h) begin
					row      = 0;
					px.done  = 1;
					finished = 1;
					pad_left = 0;
				end else begin
					row = row + 1'b1;
				end
			end else begin
				col = col + 1'b1;
			end
			expected_writes.push_back(px);
			return 1;
		endfunction

		function void check_pixel(logic we, logic [FB_INDEX_W-1:0] fb_idx,
				logic [COLOR_W-1:0] color, logic done);
			fb_write_t px;
			if (expected_writes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected pixel: we=%0b idx=%0d color=%08h done=%0b",
						we, fb_idx, color, done);
				return;
			end
			px = expected_writes.pop_front();
			if (we !== px.we || fb_idx !== px.fb_idx || color !== px.color || done !== px.done) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("pixel mismatch: expected we=%0b idx=%0d color=%08h done=%0b, got we=%0b idx=%0d color=%08h done=%0b",
						px.we, px.fb_idx, px.color, px.done, we, fb_idx, color, done);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [7:0]            data_byte   = 8'd0;
	logic                  image_start = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  write_enable;
	logic [FB_INDEX_W-1:0] fb_index;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  image_done;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	pixel_scoreboard sb;
	int idle_pct  = 0;
	int stall_pct = 0;
	int fed_bytes = 0;

	bmp_pixel_stream_to_framebuffer #(
		.FB_WIDTH (FB_W),
		.FB_HEIGHT(FB_H),
		.DIM_BITS (DIM_B)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.image_start (image_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.write_enable(write_enable),
		.fb_index    (fb_index),
		.pixel_color (pixel_color),
		.image_done  (image_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Check each accepted pixel and stall the result side at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(write_enable, fb_index, pixel_color, image_done);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write every register; junk fills the bits above each field
	task automatic config_image(input int w, input int h, input bit mir, input bit td,
			input bit four, input int ox, input int oy, input bit junk);
		write_reg(REG_IMAGE_WIDTH,  {junk ? 5'($urandom) : 5'd0, 11'(w)});
		write_reg(REG_IMAGE_HEIGHT, {junk ? 5'($urandom) : 5'd0, 11'(h)});
		write_reg(REG_MIRROR_COLS,  {junk ? 15'($urandom) : 15'd0, mir});
		write_reg(REG_ROWS_TOPDOWN, {junk ? 15'($urandom) : 15'd0, td});
		write_reg(REG_FOUR_BYTE,    {junk ? 15'($urandom) : 15'd0, four});
		write_reg(REG_ORIGIN_X,     {junk ? 4'($urandom) : 4'd0, 12'(ox)});
		write_reg(REG_ORIGIN_Y,     {junk ? 4'($urandom) : 4'd0, 12'(oy)});
	endtask

	task automatic send_byte(input logic [7:0] value, input logic first);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= value;
		image_start <= first;
		do @(posedge clk); while (!in_ready);
		if (sb.accept_byte(value, first))
			fed_bytes++;
	endtask

	task automatic send_bytes(input int count, input bit first, input int restart_pct);
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom_range(0, 255)),
				(i == 0 && first) || ($urandom_range(99) < restart_pct));
	endtask

	// Hold off until every pixel is out and the pipeline has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int w, h, ew, eh, ox, oy, row_len, full, kind, img;
		bit four;
		sb = new;
		sb.reset_all();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte before any start marker is ignored
		send_byte(8'h5A, 1'b0);
		// reset settings: single 24-bit pixel, then a stray byte after the image
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hC3, 1'b0);
		wait_idle();

		// 32-bit, mirrored, top-down, origin at the far corners: off screen
		config_image(2, 1, 1, 1, 1, 2047, -2048, 0);
		repeat (4) send_byte(8'hFF, 1'b0 | (sb.finished));
		repeat (4) send_byte(8'h00, 1'b0);
		wait_idle();

		// largest sizes, pixel lands on the last framebuffer word; restart mid-pixel
		config_image(2047, 2047, 1, 0, 0, -1247, -1567, 0);
		send_byte(8'h12, 1'b1);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hBB, 1'b0);
		send_byte(8'hFE, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b0);
		wait_idle();

		// zero sizes count as one; switch depth while the alpha byte is due
		config_image(0, 0, 0, 0, 1, 0, 0, 0);
		send_byte(8'h11, 1'b1);
		send_byte(8'h22, 1'b0);
		send_byte(8'h33, 1'b0);
		wait_idle();
		write_reg(REG_FOUR_BYTE, 16'd0);
		send_byte(8'hA5, 1'b0);
		wait_idle();

		// random images
		fed_bytes = 0;
		img = 0;
		while (fed_bytes < RANDOM_BYTES) begin
			case (img % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			kind = $urandom_range(99);
			if (kind < 8) begin
				w = $urandom_range(1000, 2047);
				h = $urandom_range(1, 2047);
			end else if (kind < 14) begin
				w = $urandom_range(1, 3);
				h = 2047;
			end else begin
				w = $urandom_range(0, 6);
				h = $urandom_range(0, 4);
			end
			four = $urandom_range(1);
			case ($urandom_range(3))
				0: begin ox = $urandom_range(0, 4095) - 2048; oy = $urandom_range(0, 4095) - 2048; end
				1: begin ox = FB_W - $urandom_range(0, 8); oy = FB_H - $urandom_range(0, 6); end
				2: begin ox = -$urandom_range(0, 8); oy = -$urandom_range(0, 6); end
				default: begin ox = $urandom_range(0, 790); oy = $urandom_range(0, 470); end
			endcase
			config_image(w, h, $urandom_range(1), $urandom_range(1), four, ox, oy,
				$urandom_range(3) == 0);
			if ($urandom_range(7) == 0)
				write_reg(REG_SPARE, 16'($urandom));

			ew = (w == 0) ? 1 : w;
			eh = (h == 0) ? 1 : h;
			row_len = four ? ew * 4 : ew * 3 + ew % 4;
			full = row_len * eh;
			kind = $urandom_range(99);
			if (full > 240) begin
				// too long to finish: feed a slice, the next start abandons it
				send_bytes($urandom_range(10, 80), 1, 0);
			end else if (kind < 70) begin
				send_bytes(full + $urandom_range(0, 2), 1, 0);
			end else if (kind < 85) begin
				send_bytes($urandom_range(1, full), 1, 4);
			end else begin
				// change geometry and depth in the middle of an image
				send_bytes($urandom_range(1, full), 1, 0);
				wait_idle();
				write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(1, 6)));
				write_reg(REG_FOUR_BYTE, 16'($urandom_range(1)));
				send_bytes($urandom_range(1, 30), 0, 0);
			end
			wait_idle();
			img++;
		end

		idle_pct = 0;
		stall_pct = 0;
		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/bmpfb_pkg.sv
rtl/core/bmp_pixel_stream_to_framebuffer.sv
verif/tb_bmp_pixel_stream_to_framebuffer.sv
